// File: hdl/tcce_pkg.sv
// Text console cursor engine: shared constants.
// Field widths, command codes, control characters and cell reset value.
// No dependencies.
package tcce_pkg;

  localparam int CMD_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 4;
  localparam int CELL_W    = 12;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 4'h7;
  localparam logic [CELL_W-1:0]  CELL_RESET  = 12'h720;

endpackage

// File: hdl/text_console_cursor_engine.sv
// Text console cursor engine: top level.
// Cursor control, scroll and clear sweeps, result register.
// Depends on tcce_pkg and tcce_cell_ram.
//
// After reset the engine sweeps its ROWS*COLUMNS cell memory once, one cell
// per cycle, to load blanks; no item is accepted during that sweep (colour
// writes are taken). For printable characters and newlines that stay on
// screen, return, backspace and unused commands the result is registered at
// the edge that accepts the item. A cell read passes through the read state,
// where the registered read data of the cell memory is loaded into the result.
// A scroll (leaving the last row) and a clear sweep the cell memory one cell per
// cycle through its single write port; the finish state then registers the result.
module text_console_cursor_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcce_pkg::COLOR_W-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tcce_pkg::CMD_W-1:0]     cmd_i,
  input  logic [tcce_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcce_pkg::ROW_OUT_W-1:0] read_row_i,
  input  logic [tcce_pkg::COL_OUT_W-1:0] read_col_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tcce_pkg::ROW_OUT_W-1:0] cursor_row_o,
  output logic [tcce_pkg::COL_OUT_W-1:0] cursor_col_o,
  output logic [tcce_pkg::CELL_W-1:0]    cell_value_o
);
  import tcce_pkg::*;

  localparam int Cells = ROWS * COLUMNS;
  localparam int AW    = $clog2(Cells);
  localparam int RW    = ($clog2(ROWS) > ROW_OUT_W) ? $clog2(ROWS) : ROW_OUT_W;
  localparam int CW    = ($clog2(COLUMNS) > COL_OUT_W) ? $clog2(COLUMNS) : COL_OUT_W;

  localparam logic [AW-1:0] LAST_ADDR  = AW'(Cells - 1);
  localparam logic [AW-1:0] SCROLL_END = AW'(Cells - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_CLEAR  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [AW-1:0]      cnt_q, cnt_d;
  logic [RW-1:0]      row_q, row_d;
  logic [CW-1:0]      col_q, col_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic [COLOR_W-1:0] color_q;
  logic               wpend_q, wpend_d;
  logic [AW-1:0]      wdst_q, wdst_d;
  logic               wblank_q, wblank_d;
  logic               rd_ok_q, rd_ok_d;
  logic               out_valid_q, out_valid_d;
  logic [ROW_OUT_W-1:0] out_row_q;
  logic [COL_OUT_W-1:0] out_col_q;
  logic [CELL_W-1:0]    out_cell_q, out_cell;
  logic               out_load;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  logic               accept;
  logic               go_next_row;
  logic               rd_in_range;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      next_base;
  logic [CELL_W-1:0]  blank_cell;

  tcce_cell_ram #(
    .Depth (Cells)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign blank_cell  = {color_q, CH_BLANK};
  assign next_base   = addr_q - AW'(col_q) + ROW_STEP;
  assign rd_in_range = (int'(read_row_i) < ROWS) && (int'(read_col_i) < COLUMNS);
  assign rd_addr     = rd_in_range ?
                       AW'(int'(read_row_i) * COLUMNS + int'(read_col_i)) : '0;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    row_d       = row_q;
    col_d       = col_q;
    addr_d      = addr_q;
    wpend_d     = 1'b0;
    wdst_d      = wdst_q;
    wblank_d    = wblank_q;
    rd_ok_d     = rd_ok_q;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = blank_cell;
    ram_raddr   = rd_addr;
    out_load    = 1'b0;
    out_cell    = '0;
    go_next_row = 1'b0;

    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = CELL_RESET;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == LAST_ADDR) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_PUT: begin
              if (char_code_i == CH_NEWLINE) begin
                go_next_row = 1'b1;
              end else if (char_code_i == CH_RETURN) begin
                col_d    = '0;
                addr_d   = addr_q - AW'(col_q);
                out_load = 1'b1;
              end else if (char_code_i == CH_BACKSPACE) begin
                if (col_q != '0) begin
                  col_d  = col_q - CW'(1);
                  addr_d = addr_q - AW'(1);
                end
                ram_we    = 1'b1;
                ram_waddr = addr_d;
                ram_wdata = blank_cell;
                out_load  = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = addr_q;
                ram_wdata = {color_q, char_code_i};
                if (col_q == LAST_COL) begin
                  go_next_row = 1'b1;
                end else begin
                  col_d    = col_q + CW'(1);
                  addr_d   = addr_q + AW'(1);
                  out_load = 1'b1;
                end
              end
            end
            CMD_CLEAR: begin
              row_d   = '0;
              col_d   = '0;
              addr_d  = '0;
              cnt_d   = '0;
              state_d = ST_CLEAR;
            end
            CMD_READ: begin
              rd_ok_d = rd_in_range;
              state_d = ST_READ;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
          if (go_next_row) begin
            col_d = '0;
            if (row_q == LAST_ROW) begin
              addr_d  = SCROLL_END;
              cnt_d   = '0;
              state_d = ST_SCROLL;
            end else begin
              row_d    = row_q + RW'(1);
              addr_d   = next_base;
              out_load = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        out_load = 1'b1;
        out_cell = rd_ok_q ? ram_rdata : '0;
        state_d  = ST_IDLE;
      end
      ST_SCROLL: begin
        ram_raddr = (cnt_q < SCROLL_END) ? cnt_q + ROW_STEP : '0;
        wpend_d   = 1'b1;
        wdst_d    = cnt_q;
        wblank_d  = (cnt_q >= SCROLL_END);
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == LAST_ADDR) begin
          cnt_d   = '0;
          state_d = ST_FINISH;
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = blank_cell;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == LAST_ADDR) begin
          cnt_d   = '0;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // drain the shifted cell read in the previous cycle
    if (wpend_q) begin
      ram_we    = 1'b1;
      ram_waddr = wdst_q;
      ram_wdata = wblank_q ? blank_cell : ram_rdata;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      addr_q      <= '0;
      color_q     <= COLOR_RESET;
      wpend_q     <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      col_q       <= col_d;
      addr_q      <= addr_d;
      wpend_q     <= wpend_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wdst_q   <= wdst_d;
    wblank_q <= wblank_d;
    if (out_load) begin
      out_row_q  <= row_d[ROW_OUT_W-1:0];
      out_col_q  <= col_d[COL_OUT_W-1:0];
      out_cell_q <= out_cell;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign cell_value_o = out_cell_q;

  a_addr_tracks_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    addr_q == AW'(int'(row_q) * COLUMNS + int'(col_q)))
    else $error("cursor address out of step with row and column");

  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(row_q) < ROWS) && (int'(col_q) < COLUMNS))
    else $error("cursor left the screen");

  a_pending_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpend_q |-> (state_q == ST_SCROLL || state_q == ST_FINISH))
    else $error("shift write pending outside a scroll");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("waiting result overwritten");

endmodule

// File: hdl/tcce_cell_ram.sv
// Text console cursor engine: character cell memory.
// One write port, one read port, registered read data.
// Depends on tcce_pkg.
module tcce_cell_ram #(
  parameter int Depth = 2000,
  localparam int AW = $clog2(Depth)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [tcce_pkg::CELL_W-1:0] wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [tcce_pkg::CELL_W-1:0] rdata_o
);
  import tcce_pkg::*;

  logic [CELL_W-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
